FILE: rtl/core/trest_pkg.sv
// Shared types, constants and coefficient tables for the track resolution estimator.
package trest_pkg;

   localparam int PT_BITS        = 24;
   localparam int ETA_BITS       = 16;
   localparam int LOG_TABLE_BITS = 8;
   localparam int ETA_FRAC_BITS  = 13;
   localparam int NPAR           = 5;
   localparam int K_BITS         = $clog2(PT_BITS);
   localparam int L2_BITS        = K_BITS + 16;
   localparam int LN2_BITS       = 30;
   localparam int REM_BITS       = L2_BITS + 1;
   localparam int QUO_BITS       = 32;
   localparam int DIV_NUM_EXP    = 46;
   localparam int DIV_BITS_STEP  = 4;
   localparam int U_BITS         = 2 * ETA_BITS;
   localparam int LOG_SIZE       = 1 << LOG_TABLE_BITS;

   localparam logic [LN2_BITS-1:0] LN2_Q30  = LN2_BITS'(744261118);
   localparam logic [REM_BITS-1:0] REM_INIT = REM_BITS'(1 << (DIV_NUM_EXP - QUO_BITS));
   localparam logic [63:0]         CAPV     = 64'h3FFF_FFFF_FFFF_FFFF;

   typedef logic signed [63:0] val_type;

   localparam val_type Q40 = 64'sd1099511627776;
   localparam val_type D3  = 64'sd1000;
   localparam val_type D4  = 64'sd10000;
   localparam val_type D5  = 64'sd100000;
   localparam val_type D6  = 64'sd1000000;
   localparam val_type D7  = 64'sd10000000;
   localparam val_type D8  = 64'sd100000000;
   localparam val_type D10 = 64'sd10000000000;
   localparam val_type D11 = 64'sd100000000000;
   localparam val_type D12 = 64'sd1000000000000;
   localparam val_type D13 = 64'sd10000000000000;
   localparam val_type D14 = 64'sd100000000000000;
   localparam val_type D15 = 64'sd1000000000000000;

   localparam val_type PT_COEF [NPAR][3] = '{
      '{ (109813 * Q40 + D5 / 2) / D5, -((48127 * Q40 + D5 / 2) / D5),
         (47829 * Q40 + D5 / 2) / D5 },
      '{ (486664 * Q40 + D6 / 2) / D6, -((329552 * Q40 + D6 / 2) / D6),
         (144658 * Q40 + D5 / 2) / D5 },
      '{ (628520 * Q40 + D6 / 2) / D6, (172843 * Q40 + D6 / 2) / D6,
         (473871 * Q40 + D6 / 2) / D6 },
      '{ (218823 * Q40 + D6 / 2) / D6, (55491 * Q40 + D5 / 2) / D5,
         (73290 * Q40 + D5 / 2) / D5 },
      '{ (93534 * Q40 + D5 / 2) / D5, -((33796 * Q40 + D6 / 2) / D6),
         (168742 * Q40 + D6 / 2) / D6 }
   };

   localparam val_type ETA_SIG [NPAR][6] = '{
      '{ (167 * Q40 + D5 / 2) / D5, -((380 * Q40 + D7 / 2) / D7),
         (375 * Q40 + D6 / 2) / D6, (228 * Q40 + D7 / 2) / D7,
         -((827 * Q40 + D8 / 2) / D8), (186 * Q40 + D8 / 2) / D8 },
      '{ (836 * Q40 + D6 / 2) / D6, (897 * Q40 + D7 / 2) / D7,
         (688 * Q40 + D7 / 2) / D7, (687 * Q40 + D8 / 2) / D8,
         -((873 * Q40 + D8 / 2) / D8), (189 * Q40 + D8 / 2) / D8 },
      '{ (137 * Q40 + D5 / 2) / D5, -((232 * Q40 + D6 / 2) / D6),
         (238 * Q40 + D6 / 2) / D6, (122 * Q40 + D8 / 2) / D8,
         -((123 * Q40 + D7 / 2) / D7), (110 * Q40 + D8 / 2) / D8 },
      '{ (167 * Q40 + D3 / 2) / D3, (163 * Q40 + D4 / 2) / D4,
         (138 * Q40 + D4 / 2) / D4, -((301 * Q40 + D6 / 2) / D6),
         -((112 * Q40 + D6 / 2) / D6), (129 * Q40 + D6 / 2) / D6 },
      '{ (592 * Q40 + D3 / 2) / D3, -((141 * Q40 + D4 / 2) / D4),
         (876 * Q40 + D4 / 2) / D4, (122 * Q40 + D4 / 2) / D4,
         -((182 * Q40 + D5 / 2) / D5), (302 * Q40 + D6 / 2) / D6 }
   };

   localparam val_type ETA_MEAN [NPAR][5] = '{
      '{ -((217 * Q40 + D6 / 2) / D6), (297 * Q40 + D13 / 2) / D13,
         -((865 * Q40 + D7 / 2) / D7), (386 * Q40 + D13 / 2) / D13,
         (358 * Q40 + D7 / 2) / D7 },
      '{ -((995 * Q40 + D7 / 2) / D7), -((184 * Q40 + D14 / 2) / D14),
         (398 * Q40 + D7 / 2) / D7, -((162 * Q40 + D14 / 2) / D14),
         (306 * Q40 + D8 / 2) / D8 },
      '{ (512 * Q40 + D7 / 2) / D7, -((322 * Q40 + D11 / 2) / D11),
         (682 * Q40 + D7 / 2) / D7, (835 * Q40 + D12 / 2) / D12,
         -((271 * Q40 + D7 / 2) / D7) },
      '{ (230 * Q40 + D4 / 2) / D4, (246 * Q40 + D10 / 2) / D10,
         (182 * Q40 + D5 / 2) / D5, -((232 * Q40 + D10 / 2) / D10),
         -((112 * Q40 + D5 / 2) / D5) },
      '{ (451 * Q40 + D4 / 2) / D4, -((107 * Q40 + D14 / 2) / D14),
         -((763 * Q40 + D4 / 2) / D4), -((407 * Q40 + D15 / 2) / D15),
         (332 * Q40 + D4 / 2) / D4 }
   };

   typedef logic [15:0] log_tbl_type [LOG_SIZE];

   function automatic log_tbl_type log_tbl_build();
      log_tbl_type tbl;
      logic [63:0] y;
      logic [15:0] f;
      for (int i = 0; i < LOG_SIZE; i++) begin
         y = 64'((LOG_SIZE + i) << (30 - LOG_TABLE_BITS));
         f = '0;
         for (int b = 0; b < 16; b++) begin
            y = (y * y) >> 30;
            f = {f[14:0], 1'b0};
            if (y >= (64'd1 << 31)) begin
               f[0] = 1'b1;
               y = y >> 1;
            end
         end
         tbl[i] = f;
      end
      return tbl;
   endfunction

   localparam log_tbl_type LOG_TBL = log_tbl_build();

   typedef struct packed {
      logic signed [PT_BITS-1:0]  pt_value;
      logic signed [ETA_BITS-1:0] eta_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sigma_inv_pt;
      logic signed [31:0] sigma_phi;
      logic signed [31:0] sigma_eta;
      logic signed [31:0] sigma_d0;
      logic signed [31:0] sigma_z0;
      logic signed [31:0] mean_inv_pt;
      logic signed [31:0] mean_phi;
      logic signed [31:0] mean_eta;
      logic signed [31:0] mean_d0;
      logic signed [31:0] mean_z0;
      logic               pt_invalid;
   } rsp_type;

   typedef struct packed {
      logic        neg;
      logic [63:0] p11;
      logic [63:0] p10;
      logic [63:0] p01;
      logic [63:0] p00;
   } mulpp_type;

   function automatic logic [63:0] mag64(val_type a);
      return a[63] ? 64'(-a) : 64'(a);
   endfunction

   function automatic mulpp_type mul_pp(val_type a, val_type b);
      mulpp_type   pp;
      logic [63:0] x;
      logic [63:0] y;
      x      = mag64(a);
      y      = mag64(b);
      pp.neg = a[63] ^ b[63];
      pp.p00 = {32'b0, x[31:0]} * {32'b0, y[31:0]};
      pp.p01 = {32'b0, x[31:0]} * {32'b0, y[63:32]};
      pp.p10 = {32'b0, x[63:32]} * {32'b0, y[31:0]};
      pp.p11 = {32'b0, x[63:32]} * {32'b0, y[63:32]};
      return pp;
   endfunction

   function automatic val_type mul_fin(mulpp_type pp, int s);
      logic [127:0] prod;
      logic [127:0] r;
      logic [63:0]  m;
      prod = {64'b0, pp.p00} + ({64'b0, pp.p01} << 32) + ({64'b0, pp.p10} << 32)
           + {pp.p11, 64'b0};
      r    = prod >> s;
      m    = (r > {64'b0, CAPV}) ? CAPV : r[63:0];
      return pp.neg ? val_type'(-m) : val_type'(m);
   endfunction

   function automatic val_type add_sat(val_type a, val_type b);
      val_type sum;
      sum = a + b;
      if (sum > val_type'(CAPV)) begin
         sum = val_type'(CAPV);
      end else if (sum < -val_type'(CAPV)) begin
         sum = -val_type'(CAPV);
      end
      return sum;
   endfunction

   function automatic logic signed [31:0] sat32(val_type v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/track_resolution_estimator_unit.sv
// Track resolution estimator: pipelined log, reciprocal and polynomial datapath.
// Throughput: one item per cycle while rsp_stall is low; a 4-bit-per-stage
// reciprocal divider over eight stages and two-stage Horner steps (partial
// products, then sum) set the depth.
// Stalls hold each occupied stage; empty stages keep filling from upstream.
// Reset clears all stage valid bits; the datapath registers are not reset.
module track_resolution_estimator_unit
   import trest_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NSTAGE = 17;
   localparam int LAST   = NSTAGE - 1;

   typedef struct {
      logic                       bad;
      logic [PT_BITS-1:0]         m;
      logic [K_BITS-1:0]          k;
      logic signed [ETA_BITS-1:0] eta;
      logic [U_BITS-1:0]          u;
      logic [L2_BITS-1:0]         l2;
      logic [L2_BITS-1:0]         ln;
      logic [REM_BITS-1:0]        rem;
      logic [QUO_BITS-1:0]        quo;
      val_type                    q   [NPAR];
      val_type                    e   [NPAR];
      val_type                    mu  [NPAR];
      mulpp_type                  qpp [NPAR];
      mulpp_type                  epp [NPAR];
      mulpp_type                  mpp [NPAR];
      rsp_type                    res;
   } pipe_type;

   pipe_type st_ff [NSTAGE];
   pipe_type st_in [NSTAGE];
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] adv;

   function automatic pipe_type stage_front(req_type r);
      pipe_type          n;
      logic [ETA_BITS-1:0] emag;
      n     = '{default: '0};
      n.m   = r.pt_value[PT_BITS-1] ? PT_BITS'(-r.pt_value) : PT_BITS'(r.pt_value);
      n.bad = n.m < PT_BITS'(2);
      n.k   = '0;
      for (int i = 0; i < PT_BITS; i++) begin
         if (n.m[i]) begin
            n.k = K_BITS'(i);
         end
      end
      n.eta = r.eta_value;
      emag  = r.eta_value[ETA_BITS-1] ? ETA_BITS'(-r.eta_value) : ETA_BITS'(r.eta_value);
      n.u   = {{ETA_BITS{1'b0}}, emag} * {{ETA_BITS{1'b0}}, emag};
      return n;
   endfunction

   function automatic pipe_type stage_step(int s, pipe_type p);
      pipe_type                       n;
      logic [PT_BITS-1:0]             norm;
      logic [LOG_TABLE_BITS-1:0]      idx;
      logic [L2_BITS+LN2_BITS-1:0]    lnp;
      logic [REM_BITS-1:0]            r;
      logic [QUO_BITS-1:0]            qv;
      val_type                        eta_op;
      val_type                        u_op;
      val_type                        quo_op;
      val_type                        mabs;
      int                             j;
      n      = p;
      eta_op = {{(64 - ETA_BITS){p.eta[ETA_BITS-1]}}, p.eta};
      u_op   = {{(64 - U_BITS){1'b0}}, p.u};
      quo_op = {{(64 - QUO_BITS){1'b0}}, p.quo};
      if (s == 1) begin
         norm = p.m << (K_BITS'(PT_BITS - 1) - p.k);
         idx  = norm[PT_BITS-2 -: LOG_TABLE_BITS];
         n.l2 = {p.k, 16'b0} + {{K_BITS{1'b0}}, LOG_TBL[idx]};
      end
      if (s == 2) begin
         lnp  = {{LN2_BITS{1'b0}}, p.l2} * {{L2_BITS{1'b0}}, LN2_Q30};
         n.ln = lnp[L2_BITS+LN2_BITS-1:LN2_BITS];
      end
      if (s >= 3 && s <= 10) begin
         r  = (s == 3) ? REM_INIT : p.rem;
         qv = (s == 3) ? '0 : p.quo;
         for (int b = 0; b < DIV_BITS_STEP; b++) begin
            r  = {r[REM_BITS-2:0], 1'b0};
            qv = {qv[QUO_BITS-2:0], 1'b0};
            if (r >= {1'b0, p.ln}) begin
               r     = r - {1'b0, p.ln};
               qv[0] = 1'b1;
            end
         end
         n.rem = r;
         n.quo = qv;
      end
      for (int l = 0; l < NPAR; l++) begin
         if (s >= 1 && s <= 10) begin
            j = (s - 1) / 2;
            if (s % 2 == 1) begin
               n.epp[l] = mul_pp((j == 0) ? ETA_SIG[l][5] : p.e[l], u_op);
            end else begin
               n.e[l] = add_sat(mul_fin(p.epp[l], 2 * ETA_FRAC_BITS), ETA_SIG[l][4 - j]);
            end
         end
         if (s >= 1 && s <= 8) begin
            j = (s - 1) / 2;
            if (s % 2 == 1) begin
               n.mpp[l] = mul_pp((j == 0) ? ETA_MEAN[l][4] : p.mu[l], eta_op);
            end else begin
               n.mu[l] = add_sat(mul_fin(p.mpp[l], ETA_FRAC_BITS), ETA_MEAN[l][3 - j]);
            end
         end
         if (s >= 11 && s <= 14) begin
            j = (s - 11) / 2;
            if (s % 2 == 1) begin
               n.qpp[l] = mul_pp((j == 0) ? PT_COEF[l][2] : p.q[l], quo_op);
            end else begin
               n.q[l] = add_sat(mul_fin(p.qpp[l], 30), PT_COEF[l][1 - j]);
            end
         end
         if (s == 15) begin
            n.qpp[l] = mul_pp(p.q[l], p.e[l]);
         end
      end
      if (s == 16) begin
         n.res = '0;
         if (p.bad) begin
            n.res.pt_invalid = 1'b1;
         end else begin
            n.res.sigma_inv_pt = sat32(mul_fin(p.qpp[0], 64));
            n.res.sigma_phi    = sat32(mul_fin(p.qpp[1], 64));
            n.res.sigma_eta    = sat32(mul_fin(p.qpp[2], 64));
            n.res.sigma_d0     = sat32(mul_fin(p.qpp[3], 64));
            n.res.sigma_z0     = sat32(mul_fin(p.qpp[4], 64));
            mabs = val_type'(mag64(p.mu[0]) >> 24);
            n.res.mean_inv_pt = sat32(p.mu[0][63] ? -mabs : mabs);
            mabs = val_type'(mag64(p.mu[1]) >> 24);
            n.res.mean_phi    = sat32(p.mu[1][63] ? -mabs : mabs);
            mabs = val_type'(mag64(p.mu[2]) >> 24);
            n.res.mean_eta    = sat32(p.mu[2][63] ? -mabs : mabs);
            mabs = val_type'(mag64(p.mu[3]) >> 24);
            n.res.mean_d0     = sat32(p.mu[3][63] ? -mabs : mabs);
            mabs = val_type'(mag64(p.mu[4]) >> 24);
            n.res.mean_z0     = sat32(p.mu[4][63] ? -mabs : mabs);
         end
      end
      return n;
   endfunction

   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   always_comb begin
      st_in[0]    = stage_front(req_data);
      valid_in[0] = req_valid;
      for (int i = 1; i < NSTAGE; i++) begin
         st_in[i]    = stage_step(i, st_ff[i-1]);
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (adv[i] && valid_in[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[LAST];
   assign rsp_data  = st_ff[LAST].res;

   a_ln_above_rem_init: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !st_ff[2].bad |-> st_ff[2].ln > REM_INIT[L2_BITS-1:0])
      else $error("log value too small for reciprocal divider");

   a_recip_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[10] && !st_ff[10].bad |->
         st_ff[10].quo != '0 && !st_ff[10].quo[QUO_BITS-1])
      else $error("reciprocal out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pt_invalid |->
         rsp_data.sigma_inv_pt == '0 && rsp_data.sigma_z0 == '0 &&
         rsp_data.mean_inv_pt == '0 && rsp_data.mean_z0 == '0)
      else $error("invalid item carries nonzero results");

   a_bad_flows: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST-1] && adv[LAST] |=> rsp_data.pt_invalid == $past(st_ff[LAST-1].bad))
      else $error("invalid flag lost in output stage");

endmodule
